>>> hw/rtl/pfse_pkg.sv
// Shared types, constants and key square lookup functions for the Playfair encryptor.
package pfse_pkg;

  localparam int KeyDim   = 5;
  localparam int CodeW    = 5;
  localparam int RowW     = KeyDim * CodeW;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);
  localparam int CfgIdxW  = 3;

  localparam logic [CodeW-1:0] CodeI = 5'd8;
  localparam logic [CodeW-1:0] CodeJ = 5'd9;
  localparam logic [CodeW-1:0] CodeX = 5'd23;

  typedef logic [CodeW-1:0]          code_t;
  typedef logic [2:0]                coord_t;
  typedef logic [KeyDim-1:0][RowW-1:0] key_sq_t;

  localparam key_sq_t KeyReset = {25'd2149955, 25'd6848868, 25'd25942713,
                                  25'd17283508, 25'd10755244};

  // one queue entry: the pairs completed by one character
  typedef struct packed {
    code_t p0_a;
    code_t p0_b;
    code_t p1_a;
    code_t p1_b;
    logic  two_pairs;
    logic  eom;
  } rec_t;

  typedef struct packed {
    coord_t r;
    coord_t c;
  } pos_t;

  function automatic code_t sq_cell(input key_sq_t k, input coord_t r, input coord_t c);
    logic [RowW-1:0] row;
    code_t           res;
    row = '0;
    res = '0;
    case (r)
      3'd0:    row = k[0];
      3'd1:    row = k[1];
      3'd2:    row = k[2];
      3'd3:    row = k[3];
      3'd4:    row = k[4];
      default: row = k[0];
    endcase
    case (c)
      3'd0:    res = row[4:0];
      3'd1:    res = row[9:5];
      3'd2:    res = row[14:10];
      3'd3:    res = row[19:15];
      3'd4:    res = row[24:20];
      default: res = row[4:0];
    endcase
    return res;
  endfunction

  function automatic coord_t wrap_inc(input coord_t v);
    return (v == coord_t'(KeyDim - 1)) ? '0 : coord_t'(v + 3'd1);
  endfunction

  // first match in row-major order wins; no match gives row 0, column 0
  function automatic pos_t locate(input key_sq_t k, input code_t code);
    pos_t p;
    p = '0;
    for (int r = KeyDim - 1; r >= 0; r--) begin
      for (int c = KeyDim - 1; c >= 0; c--) begin
        if (k[r][c*CodeW +: CodeW] == code) begin
          p.r = coord_t'(r);
          p.c = coord_t'(c);
        end
      end
    end
    return p;
  endfunction

endpackage

>>> hw/rtl/pfse_front.sv
// Front end: takes characters, prepares letters, inserts X fillers and forms pairs.
module pfse_front import pfse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       end_of_text,
  input  logic       q_full,
  output logic       push,
  output rec_t       push_rec
);

  code_t held_letter, held_letter_next;
  logic  held_valid, held_valid_next;
  code_t previous_letter, previous_letter_next;
  logic  previous_valid, previous_valid_next;

  logic       is_letter;
  code_t      code;
  code_t      slot [4];
  logic [2:0] cnt;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_letter = 1'b0;
    code      = '0;
    if (in_char >= 8'h41 && in_char <= 8'h5a) begin
      is_letter = 1'b1;
      code      = code_t'(in_char - 8'h41);
    end else if (in_char >= 8'h61 && in_char <= 8'h7a) begin
      is_letter = 1'b1;
      code      = code_t'(in_char - 8'h61);
    end
    if (code == CodeJ) code = CodeI;
  end

  // prepared stream for this word, starting with the held letter
  always_comb begin
    for (int i = 0; i < 4; i++) slot[i] = '0;
    cnt = '0;
    if (held_valid) begin
      slot[0] = held_letter;
      cnt     = 3'd1;
    end
    if (is_letter) begin
      if (previous_valid && previous_letter == code) begin
        slot[cnt[1:0]] = CodeX;
        cnt            = cnt + 3'd1;
      end
      slot[cnt[1:0]] = code;
      cnt            = cnt + 3'd1;
    end
    if (end_of_text && cnt[0]) begin
      slot[cnt[1:0]] = CodeX;
      cnt            = cnt + 3'd1;
    end
  end

  always_comb begin
    held_letter_next     = end_of_text ? '0 : (cnt[0] ? slot[{cnt[1], 1'b0}] : held_letter);
    held_valid_next      = !end_of_text && cnt[0];
    previous_letter_next = end_of_text ? '0 : (is_letter ? code : previous_letter);
    previous_valid_next  = !end_of_text && (is_letter || previous_valid);
  end

  always_comb begin
    push_rec.p0_a      = slot[0];
    push_rec.p0_b      = slot[1];
    push_rec.p1_a      = slot[2];
    push_rec.p1_b      = slot[3];
    push_rec.two_pairs = cnt[2];
    push_rec.eom       = end_of_text;
    push               = accept && (cnt[2] || cnt[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter     <= '0;
      held_valid      <= 1'b0;
      previous_letter <= '0;
      previous_valid  <= 1'b0;
    end else if (accept) begin
      held_letter     <= held_letter_next;
      held_valid      <= held_valid_next;
      previous_letter <= previous_letter_next;
      previous_valid  <= previous_valid_next;
    end
  end

endmodule

>>> hw/rtl/pfse_queue.sv
// Small register queue of pair records between front and back end.
module pfse_queue import pfse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output rec_t pop_rec,
  output logic nonempty
);

  rec_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign full     = (count == QCntW'(QDepth));
  assign nonempty = (count != '0);
  assign pop_rec  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= QPtrW'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= QPtrW'(rd_ptr + 1'b1);
      if (push && !pop)      count <= QCntW'(count + 1'b1);
      else if (pop && !push) count <= QCntW'(count - 1'b1);
    end
  end

endmodule

>>> hw/rtl/pfse_cipher.sv
// Playfair substitution of one letter pair against the key square.
module pfse_cipher import pfse_pkg::*; (
  input  key_sq_t key,
  input  code_t   a,
  input  code_t   b,
  output code_t   ca,
  output code_t   cb
);

  pos_t pa, pb;

  assign pa = locate(key, a);
  assign pb = locate(key, b);

  always_comb begin
    if (pa.r == pb.r) begin
      ca = sq_cell(key, pa.r, wrap_inc(pa.c));
      cb = sq_cell(key, pb.r, wrap_inc(pb.c));
    end else if (pa.c == pb.c) begin
      ca = sq_cell(key, wrap_inc(pa.r), pa.c);
      cb = sq_cell(key, wrap_inc(pb.r), pb.c);
    end else begin
      ca = sq_cell(key, pa.r, pb.c);
      cb = sq_cell(key, pb.r, pa.c);
    end
  end

endmodule

>>> hw/rtl/pfse_back.sv
// Back end: walks a record letter by letter, encrypts and drives the output register.
module pfse_back import pfse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  key_sq_t key,
  input  logic    q_nonempty,
  input  rec_t    q_rec,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output code_t   cipher_letter,
  output logic    last_of_run,
  output logic    end_of_message
);

  rec_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       can_load, cur_last;
  code_t      sel_a, sel_b, ca, cb;

  assign can_load = !out_valid || out_ready;
  assign cur_last = (idx == {cur.two_pairs, 1'b1});
  assign pop      = q_nonempty && (!cur_valid || (can_load && cur_last));
  assign sel_a    = idx[1] ? cur.p1_a : cur.p0_a;
  assign sel_b    = idx[1] ? cur.p1_b : cur.p0_b;

  pfse_cipher u_cipher (
    .key (key),
    .a   (sel_a),
    .b   (sel_b),
    .ca  (ca),
    .cb  (cb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (can_load) out_valid <= cur_valid;
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_valid && can_load) begin
        if (cur_last) cur_valid <= 1'b0;
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_rec;
    if (can_load && cur_valid) begin
      cipher_letter  <= idx[0] ? cb : ca;
      last_of_run    <= cur_last;
      end_of_message <= cur_last && cur.eom;
    end
  end

endmodule

>>> hw/rtl/playfair_stream_encryptor_top.sv
// Top level of the Playfair stream encryptor: key registers, front, queue and back end.
//
//   channel | handshake              | payload
//   input   | in_valid / in_ready    | in_char[7:0], end_of_text
//   output  | out_valid / out_ready  | cipher_letter[4:0], last_of_run, end_of_message
//   config  | cfg_wr_en              | cfg_index[2:0], cfg_data[24:0]
//
// Input takes one word per cycle while the 4-entry pair queue has room.
// Output gives one letter per cycle while out_ready is high; a character may release
// up to four letters, so the back end and its output register set the sustained rate.
// A completed pair goes to the queue, the current record, then the output register.
// Synchronous reset loads the default key square and empties all state; no clearing pass.
// A stalled output holds its word; the queue lets input run ahead until it fills.
module playfair_stream_encryptor_top import pfse_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char,
  input  logic               end_of_text,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CodeW-1:0]   cipher_letter,
  output logic               last_of_run,
  output logic               end_of_message,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [RowW-1:0]    cfg_data
);

  key_sq_t key;
  logic    push, q_full, pop, q_nonempty;
  rec_t    push_rec, pop_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= KeyReset;
    end else if (cfg_wr_en && cfg_index < CfgIdxW'(KeyDim)) begin
      key[cfg_index] <= cfg_data;
    end
  end

  pfse_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .push        (push),
    .push_rec    (push_rec)
  );

  pfse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .nonempty (q_nonempty)
  );

  pfse_back u_back (
    .clk            (clk),
    .rst            (rst),
    .key            (key),
    .q_nonempty     (q_nonempty),
    .q_rec          (pop_rec),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cipher_letter  (cipher_letter),
    .last_of_run    (last_of_run),
    .end_of_message (end_of_message)
  );

endmodule

>>> hw/rtl/pfse_checker.sv
// Port-level checks for the Playfair encryptor, bound to the top level.
module pfse_checker import pfse_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CodeW-1:0] cipher_letter,
  input logic             last_of_run,
  input logic             end_of_message
);

  // message end always closes the run of its character
  a_eom_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_message |-> last_of_run)
    else $error("end_of_message without last_of_run");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cipher_letter)
      && $stable(last_of_run) && $stable(end_of_message))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind playfair_stream_encryptor_top pfse_checker u_pfse_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .cipher_letter  (cipher_letter),
  .last_of_run    (last_of_run),
  .end_of_message (end_of_message)
);
